/* rtl/rtws_pkg.sv */
// shared types and constants of the record table with sort
package rtws_pkg;

  // table geometry and field widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CAT_W    = 2;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 3;

  // category code that marks a missing category
  localparam logic [CAT_W-1:0] CAT_NONE = '0;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_MODIFY    = 3'd2,
    OP_FIND      = 3'd3,
    OP_SORT_ASC  = 3'd4,
    OP_SORT_DESC = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  // status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_CAT   = 3'd4
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_SORT,
    S_SWAP_A,
    S_SWAP_B,
    S_DONE
  } state_e;

  // one stored record
  typedef struct packed {
    logic [CAT_W-1:0] cat;
    logic [ID_W-1:0]  id;
  } rec_t;

endpackage

/* rtl/rtws_in_if.sv */
// request channel: operation and operands
interface rtws_in_if;
  logic                           valid;
  logic                           ready;
  logic [rtws_pkg::OP_W-1:0]      op;
  logic [rtws_pkg::ID_W-1:0]      key_id;
  logic [rtws_pkg::ID_W-1:0]      new_id;
  logic [rtws_pkg::CAT_W-1:0]     new_category;

  modport source (output valid, op, key_id, new_id, new_category, input ready);
  modport sink   (input valid, op, key_id, new_id, new_category, output ready);
endinterface

/* rtl/rtws_out_if.sv */
// response channel: status, matched record and table size
interface rtws_out_if;
  logic                           valid;
  logic                           ready;
  logic [rtws_pkg::ST_W-1:0]      status;
  logic [rtws_pkg::IDX_W-1:0]     match_index;
  logic [rtws_pkg::ID_W-1:0]      match_id;
  logic [rtws_pkg::CAT_W-1:0]     match_category;
  logic [rtws_pkg::CNT_W-1:0]     entry_total;

  modport source (output valid, status, match_index, match_id, match_category,
                  entry_total, input ready);
  modport sink   (input valid, status, match_index, match_id, match_category,
                  entry_total, output ready);
endinterface

/* rtl/rtws_ram.sv */
// generic simple dual-port ram with registered read
module rtws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/record_table_with_sort.sv */
// record table top level: controller around one record ram
// find, modify, delete and sort walk over the ram with one read issued per cycle;
//   append, clear and the empty-table errors finish without a walk
// throughput: one operation at a time, the next taken while a result waits
// reset: entry count cleared, record ram left unwritten (no clearing pass)
module record_table_with_sort (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtws_in_if.sink           in_i,
  rtws_out_if.source        out_o
);

  localparam int unsigned IDX_W = rtws_pkg::IDX_W;
  localparam int unsigned CNT_W = rtws_pkg::CNT_W;
  localparam int unsigned ID_W  = rtws_pkg::ID_W;
  localparam int unsigned CAT_W = rtws_pkg::CAT_W;
  localparam int unsigned REC_W = $bits(rtws_pkg::rec_t);

  // control state
  rtws_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rd_vld_q, rd_vld_d;
  logic             out_vld_q, out_vld_d;

  // operands and working registers
  rtws_pkg::op_e    op_q, op_d;
  logic [ID_W-1:0]  key_q, key_d;
  logic [ID_W-1:0]  nid_q, nid_d;
  logic [CAT_W-1:0] ncat_q, ncat_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] pass_q, pass_d;
  rtws_pkg::rec_t   best_q, best_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  rtws_pkg::rec_t   head_q, head_d;

  // staged result
  rtws_pkg::status_e res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  rtws_pkg::rec_t    res_rec_q, res_rec_d;

  // output register
  rtws_pkg::status_e out_status_q;
  logic [IDX_W-1:0]  out_idx_q;
  rtws_pkg::rec_t    out_rec_q;
  logic [CNT_W-1:0]  out_total_q;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rtws_pkg::rec_t   ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata_raw;
  rtws_pkg::rec_t   ram_rdata;

  // shared conditions
  logic accept;
  logic out_free;
  logic hit;
  logic issue_done;
  logic drain;
  logic take;
  logic last_pass;
  logic tbl_empty;
  logic tbl_full;
  logic swap_needed;

  rtws_ram #(
    .WIDTH (REC_W),
    .DEPTH (rtws_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = rtws_pkg::rec_t'(ram_rdata_raw);

  // handshake and walk conditions
  assign accept      = in_i.valid & in_i.ready;
  assign out_free    = ~out_vld_q | out_o.ready;
  assign hit         = rd_vld_q & (ram_rdata.id == key_q);
  assign issue_done  = (ptr_q == count_q);
  assign drain       = issue_done & ~rd_vld_q;
  assign take        = rd_vld_q & ((op_q == rtws_pkg::OP_SORT_DESC) ?
                                   (best_q.id < ram_rdata.id) :
                                   (best_q.id > ram_rdata.id));
  assign last_pass   = ((pass_q + CNT_W'(2)) >= count_q);
  assign tbl_empty   = (count_q == '0);
  assign tbl_full    = (count_q == CNT_W'(rtws_pkg::CAPACITY));
  assign swap_needed = (best_idx_q != pass_q[IDX_W-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtws_pkg::S_IDLE: begin
        if (accept) state_d = rtws_pkg::S_EXEC;
      end
      rtws_pkg::S_EXEC: begin
        case (op_q)
          rtws_pkg::OP_DELETE, rtws_pkg::OP_MODIFY, rtws_pkg::OP_FIND: begin
            state_d = tbl_empty ? rtws_pkg::S_DONE : rtws_pkg::S_SCAN;
          end
          rtws_pkg::OP_SORT_ASC, rtws_pkg::OP_SORT_DESC: begin
            state_d = (count_q <= CNT_W'(1)) ? rtws_pkg::S_DONE : rtws_pkg::S_SORT;
          end
          default: state_d = rtws_pkg::S_DONE;
        endcase
      end
      rtws_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (op_q == rtws_pkg::OP_DELETE) ? rtws_pkg::S_SHIFT : rtws_pkg::S_DONE;
        end else if (drain) begin
          state_d = rtws_pkg::S_DONE;
        end
      end
      rtws_pkg::S_SHIFT: begin
        if (drain) state_d = rtws_pkg::S_DONE;
      end
      rtws_pkg::S_SORT: begin
        if (drain) begin
          if (swap_needed)    state_d = rtws_pkg::S_SWAP_A;
          else if (last_pass) state_d = rtws_pkg::S_DONE;
        end
      end
      rtws_pkg::S_SWAP_A: state_d = rtws_pkg::S_SWAP_B;
      rtws_pkg::S_SWAP_B: begin
        state_d = last_pass ? rtws_pkg::S_DONE : rtws_pkg::S_SORT;
      end
      rtws_pkg::S_DONE: begin
        if (out_free) state_d = rtws_pkg::S_IDLE;
      end
      default: state_d = rtws_pkg::S_IDLE;
    endcase
  end

  // datapath, ram control and result staging
  always_comb begin
    count_d      = count_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    op_d         = op_q;
    key_d        = key_q;
    nid_d        = nid_q;
    ncat_d       = ncat_q;
    ptr_d        = ptr_q;
    pass_d       = pass_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    head_d       = head_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_rec_d    = res_rec_q;
    out_vld_d    = out_vld_q & ~out_o.ready;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = '{cat: ncat_q, id: nid_q};
    ram_raddr    = ptr_q[IDX_W-1:0];

    case (state_q)
      // latch the operands of a new transaction
      rtws_pkg::S_IDLE: begin
        if (accept) begin
          op_d   = rtws_pkg::op_e'(in_i.op);
          key_d  = in_i.key_id;
          nid_d  = in_i.new_id;
          ncat_d = in_i.new_category;
        end
      end
      // checks, and the operations that finish here: append, clear and unused codes
      rtws_pkg::S_EXEC: begin
        res_status_d = rtws_pkg::ST_OK;
        res_idx_d    = '0;
        res_rec_d    = '0;
        ptr_d        = '0;
        pass_d       = '0;
        case (op_q)
          rtws_pkg::OP_APPEND: begin
            if (ncat_q == rtws_pkg::CAT_NONE) begin
              res_status_d = rtws_pkg::ST_BAD_CAT;
            end else if (tbl_full) begin
              res_status_d = rtws_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              res_idx_d = count_q[IDX_W-1:0];
              res_rec_d = '{cat: ncat_q, id: nid_q};
              count_d   = count_q + CNT_W'(1);
            end
          end
          rtws_pkg::OP_DELETE, rtws_pkg::OP_MODIFY, rtws_pkg::OP_FIND,
          rtws_pkg::OP_SORT_ASC, rtws_pkg::OP_SORT_DESC: begin
            if (tbl_empty) res_status_d = rtws_pkg::ST_EMPTY;
          end
          rtws_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          default: ;
        endcase
      end
      // linear search, one read issued per cycle
      rtws_pkg::S_SCAN: begin
        if (hit) begin
          if (op_q == rtws_pkg::OP_MODIFY && ncat_q == rtws_pkg::CAT_NONE) begin
            res_status_d = rtws_pkg::ST_BAD_CAT;
          end else begin
            res_idx_d = rd_idx_q;
            res_rec_d = ram_rdata;
            if (op_q == rtws_pkg::OP_MODIFY) begin
              ram_we    = 1'b1;
              ram_waddr = rd_idx_q;
            end
          end
          ptr_d = CNT_W'(rd_idx_q) + CNT_W'(1);
        end else if (!issue_done) begin
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
          ptr_d    = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          res_status_d = rtws_pkg::ST_NOT_FOUND;
        end
      end
      // move later records down one place
      rtws_pkg::S_SHIFT: begin
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue_done) begin
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
          ptr_d    = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      // one selection pass over the unsorted tail
      rtws_pkg::S_SORT: begin
        if (rd_vld_q) begin
          if (rd_idx_q == pass_q[IDX_W-1:0]) begin
            best_d     = ram_rdata;
            best_idx_d = rd_idx_q;
            head_d     = ram_rdata;
          end else if (take) begin
            best_d     = ram_rdata;
            best_idx_d = rd_idx_q;
          end
        end
        if (!issue_done) begin
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
          ptr_d    = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q && !swap_needed) begin
          pass_d = pass_q + CNT_W'(1);
          ptr_d  = pass_q + CNT_W'(1);
        end
      end
      // swap the chosen record into the head of the tail
      rtws_pkg::S_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = pass_q[IDX_W-1:0];
        ram_wdata = best_q;
      end
      rtws_pkg::S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = head_q;
        pass_d    = pass_q + CNT_W'(1);
        ptr_d     = pass_q + CNT_W'(1);
      end
      // hand the result to the output register
      rtws_pkg::S_DONE: begin
        if (out_free) out_vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rtws_pkg::S_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    nid_q        <= nid_d;
    ncat_q       <= ncat_d;
    ptr_q        <= ptr_d;
    rd_idx_q     <= rd_idx_d;
    pass_q       <= pass_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    head_q       <= head_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_rec_q    <= res_rec_d;
    if (state_q == rtws_pkg::S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_rec_q    <= res_rec_q;
      out_total_q  <= count_q;
    end
  end

  // channel outputs
  assign in_i.ready           = (state_q == rtws_pkg::S_IDLE);
  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_status_q;
  assign out_o.match_index    = out_idx_q;
  assign out_o.match_id       = out_rec_q.id;
  assign out_o.match_category = out_rec_q.cat;
  assign out_o.entry_total    = out_total_q;

endmodule

/* tb/tb_top.sv */
// testbench for the record table with sort: directed and random operations
`timescale 1ns / 1ps

module tb_top;

  // op code with no operation behind it
  localparam logic [rtws_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  // one expected or observed result transaction
  typedef struct packed {
    logic [rtws_pkg::ST_W-1:0]  status;
    logic [rtws_pkg::IDX_W-1:0] index;
    logic [rtws_pkg::ID_W-1:0]  id;
    logic [rtws_pkg::CAT_W-1:0] cat;
    logic [rtws_pkg::CNT_W-1:0] total;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  rtws_in_if  req_bus ();
  rtws_out_if rsp_bus ();

  record_table_with_sort dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (rsp_bus)
  );

  // predicted table contents
  logic [rtws_pkg::ID_W-1:0]  rec_ids  [rtws_pkg::CAPACITY];
  logic [rtws_pkg::CAT_W-1:0] rec_cats [rtws_pkg::CAPACITY];
  int                         rec_count;

  table_result_t expected_results [$];
  int            err_count;
  int            hold_cycles;
  bit            gaps_enabled;
  int            burst_left;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // run limit
  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    err_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
  endtask

  // table behavior for one operation, updates the predicted table
  function automatic table_result_t apply_operation(
      input logic [rtws_pkg::OP_W-1:0]  op,
      input logic [rtws_pkg::ID_W-1:0]  key,
      input logic [rtws_pkg::ID_W-1:0]  nid,
      input logic [rtws_pkg::CAT_W-1:0] cat);
    table_result_t r;
    int pos;
    int i;
    int j;
    int pick;
    bit descending;
    logic [rtws_pkg::ID_W-1:0]  t_id;
    logic [rtws_pkg::CAT_W-1:0] t_cat;
    r = '0;
    r.status = rtws_pkg::ST_OK;
    pos = -1;
    case (op)
      rtws_pkg::OP_APPEND: begin
        if (cat == rtws_pkg::CAT_NONE) begin
          r.status = rtws_pkg::ST_BAD_CAT;
        end else if (rec_count >= rtws_pkg::CAPACITY) begin
          r.status = rtws_pkg::ST_FULL;
        end else begin
          rec_ids[rec_count]  = nid;
          rec_cats[rec_count] = cat;
          r.index = rtws_pkg::IDX_W'(rec_count);
          r.id    = nid;
          r.cat   = cat;
          rec_count++;
        end
      end
      rtws_pkg::OP_DELETE, rtws_pkg::OP_MODIFY, rtws_pkg::OP_FIND: begin
        if (rec_count == 0) begin
          r.status = rtws_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < rec_count; i++)
            if (pos < 0 && rec_ids[i] == key) pos = i;
          if (pos < 0) begin
            r.status = rtws_pkg::ST_NOT_FOUND;
          end else if (op == rtws_pkg::OP_MODIFY && cat == rtws_pkg::CAT_NONE) begin
            r.status = rtws_pkg::ST_BAD_CAT;
          end else begin
            r.index = rtws_pkg::IDX_W'(pos);
            r.id    = rec_ids[pos];
            r.cat   = rec_cats[pos];
            if (op == rtws_pkg::OP_DELETE) begin
              for (i = pos; i + 1 < rec_count; i++) begin
                rec_ids[i]  = rec_ids[i+1];
                rec_cats[i] = rec_cats[i+1];
              end
              rec_count--;
            end else if (op == rtws_pkg::OP_MODIFY) begin
              rec_ids[pos]  = nid;
              rec_cats[pos] = cat;
            end
          end
        end
      end
      rtws_pkg::OP_SORT_ASC, rtws_pkg::OP_SORT_DESC: begin
        if (rec_count == 0) begin
          r.status = rtws_pkg::ST_EMPTY;
        end else begin
          // selection sort, strict compare, swap only on a new pick
          descending = (op == rtws_pkg::OP_SORT_DESC);
          for (i = 0; i < rec_count; i++) begin
            pick = i;
            for (j = i + 1; j < rec_count; j++)
              if (descending ? (rec_ids[pick] < rec_ids[j]) : (rec_ids[pick] > rec_ids[j]))
                pick = j;
            if (pick != i) begin
              t_id           = rec_ids[i];
              t_cat          = rec_cats[i];
              rec_ids[i]     = rec_ids[pick];
              rec_cats[i]    = rec_cats[pick];
              rec_ids[pick]  = t_id;
              rec_cats[pick] = t_cat;
            end
          end
        end
      end
      rtws_pkg::OP_CLEAR: rec_count = 0;
      default: ;
    endcase
    r.total = rtws_pkg::CNT_W'(rec_count);
    return r;
  endfunction

  // send one request transaction, with burst gaps when enabled
  task automatic send_request(input logic [rtws_pkg::OP_W-1:0]  op,
                              input logic [rtws_pkg::ID_W-1:0]  key,
                              input logic [rtws_pkg::ID_W-1:0]  nid,
                              input logic [rtws_pkg::CAT_W-1:0] cat);
    int gap;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk_i);
          req_bus.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk_i);
    req_bus.valid        <= 1'b1;
    req_bus.op           <= op;
    req_bus.key_id       <= key;
    req_bus.new_id       <= nid;
    req_bus.new_category <= cat;
    do @(posedge clk_i); while (!req_bus.ready);
    expected_results.push_back(apply_operation(op, key, nid, cat));
  endtask

  // id of a stored record or a random one
  function automatic logic [rtws_pkg::ID_W-1:0] pick_key();
    if (rec_count > 0 && $urandom_range(0, 3) != 0)
      return rec_ids[$urandom_range(0, rec_count - 1)];
    return rtws_pkg::ID_W'($urandom);
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    table_result_t exp_r;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(rsp_bus.status), 0);
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_bus.status != exp_r.status)
          report_mismatch("status", 32'(rsp_bus.status), 32'(exp_r.status));
        if (rsp_bus.match_index != exp_r.index)
          report_mismatch("match_index", 32'(rsp_bus.match_index), 32'(exp_r.index));
        if (rsp_bus.match_id != exp_r.id)
          report_mismatch("match_id", 32'(rsp_bus.match_id), 32'(exp_r.id));
        if (rsp_bus.match_category != exp_r.cat)
          report_mismatch("match_category", 32'(rsp_bus.match_category), 32'(exp_r.cat));
        if (rsp_bus.entry_total != exp_r.total)
          report_mismatch("entry_total", 32'(rsp_bus.entry_total), 32'(exp_r.total));
      end
    end
  end

  // receiver stall patterns and long hold-offs
  initial begin : result_receiver
    int mode;
    int mode_left;
    int phase;
    mode = 0;
    mode_left = 0;
    phase = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= 1'($urandom_range(0, 1));
          2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= (phase % 5 != 0);
        endcase
      end
    end
  end

  // empty table: every operation
  task automatic test_empty_table();
    send_request(rtws_pkg::OP_DELETE, 16'h0000, 16'h0000, 2'd1);
    send_request(rtws_pkg::OP_MODIFY, 16'hffff, 16'h1234, 2'd0);
    send_request(rtws_pkg::OP_FIND, 16'h5a5a, 16'h0000, 2'd3);
    send_request(rtws_pkg::OP_SORT_ASC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_SORT_DESC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h7777, rtws_pkg::CAT_NONE);
    send_request(rtws_pkg::OP_CLEAR, 16'hffff, 16'hffff, 2'd3);
    send_request(OP_UNUSED, 16'hffff, 16'hffff, 2'd3);
  endtask

  // small table: extremes, duplicates, error order, shifts and sorts
  task automatic test_basic_records();
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h0000, 2'd1);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'hffff, 2'd3);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h0042, 2'd2);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h0042, 2'd3);
    send_request(rtws_pkg::OP_FIND, 16'h0042, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_FIND, 16'h1234, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_MODIFY, 16'h9999, 16'h0001, rtws_pkg::CAT_NONE);
    send_request(rtws_pkg::OP_MODIFY, 16'hffff, 16'h0001, rtws_pkg::CAT_NONE);
    send_request(rtws_pkg::OP_MODIFY, 16'hffff, 16'h8000, 2'd2);
    send_request(OP_UNUSED, 16'h0042, 16'h0042, 2'd1);
    send_request(rtws_pkg::OP_SORT_DESC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_SORT_ASC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_DELETE, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_DELETE, 16'h8000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_DELETE, 16'h0042, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_DELETE, 16'h4444, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_CLEAR, 16'h0000, 16'h0000, 2'd0);
  endtask

  // fill to capacity, then full and bad category on a full table
  task automatic test_full_table();
    int i;
    send_request(rtws_pkg::OP_CLEAR, 16'h0000, 16'h0000, 2'd0);
    for (i = 0; i < rtws_pkg::CAPACITY; i++)
      send_request(rtws_pkg::OP_APPEND, 16'h0000, rtws_pkg::ID_W'($urandom),
                   rtws_pkg::CAT_W'($urandom_range(1, 3)));
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h1111, 2'd1);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h1111, rtws_pkg::CAT_NONE);
    send_request(rtws_pkg::OP_FIND, rec_ids[rtws_pkg::CAPACITY-1], 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_SORT_DESC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_SORT_ASC, 16'h0000, 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_DELETE, rec_ids[rtws_pkg::CAPACITY-1], 16'h0000, 2'd0);
    send_request(rtws_pkg::OP_MODIFY, rec_ids[0], 16'hfffe, 2'd3);
    send_request(rtws_pkg::OP_APPEND, 16'h0000, 16'h2222, 2'd2);
    send_request(rtws_pkg::OP_CLEAR, 16'h0000, 16'h0000, 2'd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int i;
    gaps_enabled = 1'b0;
    @(posedge clk_i);
    hold_cycles = 300;
    for (i = 0; i < 12; i++)
      send_request((i % 3 == 2) ? rtws_pkg::OP_FIND : rtws_pkg::OP_APPEND, pick_key(),
                   rtws_pkg::ID_W'($urandom), rtws_pkg::CAT_W'($urandom_range(1, 3)));
    gaps_enabled = 1'b1;
  endtask

  // random operations on a mostly small table
  task automatic test_random_mix(input int n);
    int k;
    int r;
    logic [rtws_pkg::OP_W-1:0]  op;
    logic [rtws_pkg::ID_W-1:0]  nid;
    logic [rtws_pkg::CAT_W-1:0] cat;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30 && rec_count >= 28 && $urandom_range(0, 1) == 1) r = 30;
      if (r < 30)      op = rtws_pkg::OP_APPEND;
      else if (r < 45) op = rtws_pkg::OP_DELETE;
      else if (r < 60) op = rtws_pkg::OP_MODIFY;
      else if (r < 78) op = rtws_pkg::OP_FIND;
      else if (r < 83) op = rtws_pkg::OP_SORT_ASC;
      else if (r < 88) op = rtws_pkg::OP_SORT_DESC;
      else if (r < 90) op = rtws_pkg::OP_CLEAR;
      else if (r < 92) op = OP_UNUSED;
      else             op = rtws_pkg::OP_W'($urandom);
      // small id pool makes duplicates common
      nid = ($urandom_range(0, 1) == 0) ? rtws_pkg::ID_W'($urandom_range(0, 15)) :
                                          rtws_pkg::ID_W'($urandom);
      cat = ($urandom_range(0, 6) == 0) ? rtws_pkg::CAT_NONE :
                                          rtws_pkg::CAT_W'($urandom_range(1, 3));
      if (r >= 92)
        send_request(op, rtws_pkg::ID_W'($urandom), rtws_pkg::ID_W'($urandom),
                     rtws_pkg::CAT_W'($urandom));
      else
        send_request(op, pick_key(), nid, cat);
      if (k % 120 == 60) begin
        @(posedge clk_i);
        hold_cycles = $urandom_range(40, 120);
      end
    end
  endtask

  // stimulus sequence and end of run
  initial begin
    err_count    = 0;
    hold_cycles  = 0;
    gaps_enabled = 1'b1;
    burst_left   = 0;
    rec_count    = 0;
    req_bus.valid        = 1'b0;
    req_bus.op           = rtws_pkg::OP_APPEND;
    req_bus.key_id       = '0;
    req_bus.new_id       = '0;
    req_bus.new_category = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_basic_records();
    test_backpressure();
    test_full_table();
    test_random_mix(340);

    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rtws_pkg.sv
rtl/rtws_in_if.sv
rtl/rtws_out_if.sv
rtl/rtws_ram.sv
rtl/record_table_with_sort.sv
tb/tb_top.sv
